/* rtl/assert_macros.svh */
// assertion macros shared by the checker modules
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define DMWT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define DMWT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/dmwt_pkg.sv */
// shared types and constants for the direct-mapped write-back tag store
// no dependencies; compiled before every other module of the block
package dmwt_pkg;

  // geometry, powers of two
  localparam int SLOT_COUNT = 1024;
  localparam int PAGE_BYTES = 4096;

  localparam int OFFSET_W   = 48;
  localparam int LEN_W      = 13;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int PAGE_W     = OFFSET_W - PAGE_SHIFT;
  localparam int TAG_W      = PAGE_W - SLOT_W;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  // result field widths
  localparam int EVICT_W    = 36;
  localparam int SLOT_OUT_W = 10;
  localparam int FCNT_W     = 11;

  localparam int TDATA_W    = 64;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_STAGING_EN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_LIMIT = CFG_IDX_W'(1);
  localparam logic [LEN_W-1:0]     LIMIT_RESET     = LEN_W'(4096);

  // request kinds carried on tuser
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic [TDATA_W-OFFSET_W-LEN_W-1:0] pad;
    logic [LEN_W-1:0]                  write_length;
    logic [OFFSET_W-1:0]               byte_offset;
  } in_beat_t;

  typedef struct packed {
    logic [TDATA_W-FCNT_W-1-SLOT_OUT_W-EVICT_W-2-1:0] pad;
    logic [FCNT_W-1:0]     flushed_count;
    logic                  flush_kick;
    logic [SLOT_OUT_W-1:0] slot_used;
    logic [EVICT_W-1:0]    evicted_page;
    logic                  evicted;
    logic                  accepted;
  } out_beat_t;

  // one tag store entry
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_WALK,
    ST_WALK_TAIL,
    ST_FLUSH_OUT
  } state_e;

  typedef struct packed {
    logic load;       // input beat taken
    logic rd_item;    // read address from the incoming beat
    logic rd_walk;    // read address from the slot counter
    logic idx_rst;
    logic idx_inc;
    logic clr_wr;     // write an empty entry at the slot counter
    logic walk_rd;    // walk read issued, write-back follows next cycle
    logic update;     // finish a write request
    logic flush_done; // finish a flush-all
  } dp_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/dmwt_ram.sv */
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module dmwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dmwt_ctrl.sv */
// controller of the tag store: clearing pass, lookup/update, flush-all walk
// depends on dmwt_pkg
module dmwt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_kind_i,
  output logic                 in_ready_o,
  input  dmwt_pkg::dp_status_t status_i,
  output dmwt_pkg::dp_cmd_t    cmd_o
);
  import dmwt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (status_i.idx_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.rd_item = 1'b1;
        if (in_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.idx_rst = 1'b1;
          state_d = (in_kind_i == REQ_FLUSH) ? ST_WALK : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // result register must be free before the entry is written back
        if (status_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_WALK: begin
        cmd_o.rd_walk = 1'b1;
        cmd_o.walk_rd = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (status_i.idx_last) begin
          state_d = ST_WALK_TAIL;
        end
      end
      ST_WALK_TAIL: begin
        // last slot's write-back happens here
        state_d = ST_FLUSH_OUT;
      end
      ST_FLUSH_OUT: begin
        if (status_i.out_free) begin
          cmd_o.flush_done = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

/* rtl/dmwt_dp.sv */
// datapath of the tag store: config registers, tag ram, compare, result register
// depends on dmwt_pkg and dmwt_ram
module dmwt_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [dmwt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dmwt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  dmwt_pkg::in_beat_t   in_beat_i,
  input  logic                 in_kind_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output dmwt_pkg::out_beat_t  out_beat_o,
  input  dmwt_pkg::dp_cmd_t    cmd_i,
  output dmwt_pkg::dp_status_t status_o
);
  import dmwt_pkg::*;

  logic             stage_en_q;
  logic [LEN_W-1:0] limit_q;
  logic             pending_q, pending_d;

  logic [SLOT_W-1:0] idx_q, idx_d;
  logic              wb_en_q;
  logic [SLOT_W-1:0] wb_addr_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic [SLOT_W-1:0] slot_q;
  logic [TAG_W-1:0]  tag_q;
  logic              ok_q;

  logic              out_valid_q, out_valid_d;
  out_beat_t         out_q, out_d;

  logic [SLOT_W-1:0] in_slot;
  logic [TAG_W-1:0]  in_tag;
  logic              in_ok;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  entry_t            ram_wdata, rd_entry;
  logic              evict;

  assign in_slot = in_beat_i.byte_offset[PAGE_SHIFT +: SLOT_W];
  assign in_tag  = in_beat_i.byte_offset[OFFSET_W-1 : PAGE_SHIFT+SLOT_W];
  assign in_ok   = (in_kind_i == REQ_WRITE) && stage_en_q
                && (in_beat_i.write_length != '0)
                && (in_beat_i.write_length <= limit_q);

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_en_q <= 1'b0;
      limit_q    <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STAGING_EN:  stage_en_q <= cfg_wdata_i[0];
        REG_WRITE_LIMIT: limit_q    <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      slot_q <= in_slot;
      tag_q  <= in_tag;
      ok_q   <= in_ok;
    end
    wb_addr_q <= idx_q;
  end

  assign ram_raddr = cmd_i.rd_walk ? idx_q : (cmd_i.rd_item ? in_slot : slot_q);

  dmwt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_entry)
  );

  // dirty entries only; invalid entries are never dirty
  assign evict = rd_entry.dirty && (!rd_entry.valid || (rd_entry.tag != tag_q));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = '{tag: tag_q, valid: 1'b1, dirty: 1'b1};
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    pending_d = pending_q;
    out_d     = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.idx_rst) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + SLOT_W'(1);
    end

    if (cmd_i.load) begin
      cnt_d = '0;
    end

    if (cmd_i.clr_wr) begin
      ram_we    = 1'b1;
      ram_waddr = idx_q;
      ram_wdata = '0;
    end else if (wb_en_q && rd_entry.dirty) begin
      // walk write-back of the entry read in the cycle before
      ram_we    = 1'b1;
      ram_waddr = wb_addr_q;
      ram_wdata = '{tag: rd_entry.tag, valid: rd_entry.valid, dirty: 1'b0};
      cnt_d     = cnt_q + CNT_W'(1);
    end else if (cmd_i.update && ok_q) begin
      ram_we = 1'b1;
    end

    if (cmd_i.update) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      if (ok_q) begin
        out_d.accepted   = 1'b1;
        out_d.evicted    = evict;
        out_d.evicted_page = evict ? EVICT_W'({rd_entry.tag, slot_q}) : '0;
        out_d.slot_used  = SLOT_OUT_W'(slot_q);
        out_d.flush_kick = !pending_q;
        pending_d        = 1'b1;
      end
    end else if (cmd_i.flush_done) begin
      out_valid_d         = 1'b1;
      out_d               = '0;
      out_d.flushed_count = FCNT_W'(cnt_q);
      pending_d           = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      wb_en_q     <= 1'b0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      wb_en_q     <= cmd_i.walk_rd;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

  assign status_o.idx_last = (idx_q == SLOT_W'(SLOT_COUNT - 1));
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_beat_o        = out_q;

endmodule

/* rtl/direct_mapped_writeback_tags.sv */
// Tag and dirty store of a direct-mapped write-back staging cache with page-sized
// slots. After reset a clearing pass over all SLOT_COUNT (1024) slots empties the
// tag ram; s_axis_tready stays low meanwhile, configuration writes are taken at
// any time. A write request does one tag ram read, then compare and write-back,
// using the ram's one read port and one write port. A flush-all goes through the
// accept cycle, one slot read per cycle with the dirty mark cleared in the cycle
// after, the last write-back and the result cycle, which waits for a free output
// register. The next request is accepted while a result still waits in the output
// register; the update step waits only if that register is still full.
// depends on dmwt_pkg, dmwt_ctrl, dmwt_dp, dmwt_ram
module direct_mapped_writeback_tags (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [dmwt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dmwt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // byte_offset[47:0], write_length[60:48], zeros above
  input  logic [dmwt_pkg::TDATA_W-1:0] s_axis_tdata,
  // req_type
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // accepted[0], evicted[1], evicted_page[37:2], slot_used[47:38],
  // flush_kick[48], flushed_count[59:49], zeros above
  output logic [dmwt_pkg::TDATA_W-1:0] m_axis_tdata
);
  import dmwt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  out_beat_t  out_beat;

  dmwt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dmwt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_beat_i   (in_beat_t'(s_axis_tdata)),
    .in_kind_i   (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_beat_o  (out_beat),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  assign m_axis_tdata = TDATA_W'(out_beat);

endmodule

/* rtl/dmwt_checker.sv */
// port-level checks of the tag store results, bound to the top level
// depends on dmwt_pkg and assert_macros.svh
`include "assert_macros.svh"

module dmwt_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [dmwt_pkg::TDATA_W-1:0] m_axis_tdata
);
  import dmwt_pkg::*;

  out_beat_t beat;
  assign beat = out_beat_t'(m_axis_tdata);

  `DMWT_ASSERT_IMP(a_out_hold, m_axis_tvalid && !m_axis_tready,
    ##1 (m_axis_tvalid && $stable(m_axis_tdata)), "result beat dropped or changed while stalled")

  `DMWT_ASSERT_IMP(a_reject_zero, m_axis_tvalid && !beat.accepted,
    !beat.evicted && beat.evicted_page == '0 && beat.slot_used == '0 && !beat.flush_kick,
    "non-staged result carries write fields")

  `DMWT_ASSERT_IMP(a_write_no_count, m_axis_tvalid && beat.accepted,
    beat.flushed_count == '0, "staged write reports a flush count")

  `DMWT_ASSERT_IMP(a_evict_page, m_axis_tvalid && !beat.evicted,
    beat.evicted_page == '0, "evicted page set without an eviction")

  `DMWT_ASSERT(a_pad_zero, !m_axis_tvalid || beat.pad == '0, "result padding not zero")

endmodule

bind direct_mapped_writeback_tags dmwt_checker u_dmwt_checker (.*);

/* tb/writeback_tags_checker.sv */
// Checker for the direct-mapped write-back tag store: tracks slot tags, dirty marks
// and configuration, predicts each result beat and compares it with the master side.
// depends on dmwt_pkg
module writeback_tags_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dmwt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dmwt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [dmwt_pkg::TDATA_W-1:0]    s_axis_tdata,
  input  logic                            s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [dmwt_pkg::TDATA_W-1:0]    m_axis_tdata,
  output int                              mismatch_count_o,
  output int                              outstanding_o
);
  import dmwt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic [PAGE_W-1:0] page_tag   [SLOT_COUNT];
  bit                page_valid [SLOT_COUNT];
  bit                page_dirty [SLOT_COUNT];
  bit                flush_pending;
  bit                staging_en;
  logic [LEN_W-1:0]  write_limit;
  out_beat_t         outcome_q [$];

  // updates the tag store copy and returns the result beat this request causes
  function automatic out_beat_t predict_outcome(logic kind, in_beat_t beat);
    out_beat_t         res;
    logic [PAGE_W-1:0] page;
    int unsigned       slot;
    int unsigned       cleared;
    res = '0;
    cleared = 0;
    if (kind == REQ_FLUSH) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (page_dirty[i]) begin
          page_dirty[i] = 1'b0;
          cleared++;
        end
      end
      flush_pending = 1'b0;
      res.flushed_count = FCNT_W'(cleared);
      return res;
    end
    if (!staging_en || beat.write_length == '0 || beat.write_length > write_limit) begin
      return res;
    end
    page = beat.byte_offset[OFFSET_W-1:PAGE_SHIFT];
    slot = int'(page[SLOT_W-1:0]);
    if (!page_valid[slot] || page_tag[slot] != page) begin
      if (page_dirty[slot]) begin
        res.evicted = 1'b1;
        res.evicted_page = EVICT_W'(page_tag[slot]);
      end
      page_tag[slot] = page;
      page_valid[slot] = 1'b1;
    end
    page_dirty[slot] = 1'b1;
    res.accepted = 1'b1;
    res.slot_used = SLOT_OUT_W'(slot);
    if (!flush_pending) begin
      flush_pending = 1'b1;
      res.flush_kick = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t got;
    out_beat_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        page_tag[i] = '0;
        page_valid[i] = 1'b0;
        page_dirty[i] = 1'b0;
      end
      flush_pending = 1'b0;
      staging_en = 1'b0;
      write_limit = LIMIT_RESET;
      outcome_q.delete();
      mismatch_count_o = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_STAGING_EN) begin
          staging_en = cfg_wdata_i[0];
        end else if (cfg_idx_i == REG_WRITE_LIMIT) begin
          write_limit = LEN_W'(cfg_wdata_i);
        end
      end
      // the result beat always belongs to an older request, so check it first
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (outcome_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10) begin
            $display("%0t: result beat with nothing expected: %h", $realtime, m_axis_tdata);
          end
        end else begin
          want = outcome_q.pop_front();
          if (got.accepted !== want.accepted || got.evicted !== want.evicted ||
              got.evicted_page !== want.evicted_page || got.slot_used !== want.slot_used ||
              got.flush_kick !== want.flush_kick ||
              got.flushed_count !== want.flushed_count) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("%0t: mismatch exp acc=%0d ev=%0d page=%h slot=%0d kick=%0d cnt=%0d",
                       $realtime, want.accepted, want.evicted, want.evicted_page,
                       want.slot_used, want.flush_kick, want.flushed_count);
              $display("%0t:          got acc=%0d ev=%0d page=%h slot=%0d kick=%0d cnt=%0d",
                       $realtime, got.accepted, got.evicted, got.evicted_page,
                       got.slot_used, got.flush_kick, got.flushed_count);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        outcome_q.push_back(predict_outcome(s_axis_tuser, in_beat_t'(s_axis_tdata)));
      end
      outstanding_o = outcome_q.size();
    end
  end

endmodule

/* tb/direct_mapped_writeback_tags_test.sv */
// Top of the tag store testbench: clock, reset, register writes and request beats
// with random gaps on both sides; the verdict comes from writeback_tags_checker.
// depends on dmwt_pkg, direct_mapped_writeback_tags, writeback_tags_checker
module direct_mapped_writeback_tags_test;
  import dmwt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 8000;
  localparam int PHASE_ITEMS    = 80;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [TDATA_W-1:0]    m_axis_tdata;
  int                    mismatches;
  int                    outstanding;
  int                    idle_cycles;
  int unsigned           cur_limit;

  direct_mapped_writeback_tags dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  writeback_tags_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // pages crowd onto a few slots and a few tags so that hits and evictions are common
  function automatic logic [OFFSET_W-1:0] random_offset();
    logic [TAG_W-1:0]      hi;
    logic [SLOT_W-1:0]     slot;
    logic [PAGE_SHIFT-1:0] lo;
    int unsigned           pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      slot = SLOT_W'($urandom_range(0, 15));
    end else if (pick < 85) begin
      slot = SLOT_W'(SLOT_COUNT - 1 - $urandom_range(0, 3));
    end else begin
      slot = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      hi = TAG_W'($urandom_range(0, 3));
    end else if (pick < 60) begin
      hi = ~TAG_W'($urandom_range(0, 1));
    end else begin
      hi = TAG_W'($urandom);
    end
    lo = PAGE_SHIFT'($urandom);
    return {hi, slot, lo};
  endfunction

  function automatic logic [LEN_W-1:0] random_length(int unsigned lim);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return '0;
    if (pick < 20) return (lim >= 4096) ? LEN_W'(4096) : LEN_W'($urandom_range(lim + 1, 4096));
    if (pick < 30) return LEN_W'(lim);
    return LEN_W'($urandom_range(1, (lim == 0) ? 4096 : lim));
  endfunction

  // called and returns at a falling edge; tvalid stays high when there is no gap
  task automatic send_request(input logic kind, input logic [OFFSET_W-1:0] off,
                              input logic [LEN_W-1:0] len);
    in_beat_t beat;
    int       gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    beat = '0;
    beat.byte_offset = off;
    beat.write_length = len;
    s_axis_tdata = beat;
    s_axis_tuser = kind;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = CFG_DATA_W'(value);
    if (idx == REG_WRITE_LIMIT) cur_limit = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // wait until every result beat has come back, then a short settle
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      int unsigned pick;
      int          span;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        m_axis_tready = 1'b1;
        span = int'($urandom_range(1, 30));
      end else if (pick < 90) begin
        m_axis_tready = 1'b0;
        span = int'($urandom_range(1, 3));
      end else begin
        m_axis_tready = 1'b0;
        span = int'($urandom_range(10, 40));
      end
      repeat (span) @(negedge clk_i);
    end
  end

  // ends the run when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned lim;
    idle_cycles = 0;
    cur_limit = 4096;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_STAGING_EN;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = REQ_WRITE;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // staging still disabled after reset
    send_request(REQ_WRITE, '0, LEN_W'(1));
    send_request(REQ_FLUSH, '0, '0);
    drain();
    write_reg(REG_STAGING_EN, 1);

    send_request(REQ_WRITE, '0, '0);
    send_request(REQ_WRITE, '0, LEN_W'(4096));
    send_request(REQ_WRITE, 48'hFFFF_FFFF_FFFF, LEN_W'(1));
    send_request(REQ_WRITE, 48'hFFFF_FFFF_F000, LEN_W'(4096));
    // same slot as the all-ones page, dirty, so it gets evicted
    send_request(REQ_WRITE, 48'h0000_003F_F000, LEN_W'(8));
    // crosses the page end, stays with its first byte
    send_request(REQ_WRITE, 48'h0000_0000_0FFF, LEN_W'(2));
    send_request(REQ_WRITE, 48'h0000_0040_0000, LEN_W'(100));
    send_request(REQ_FLUSH, '0, '0);
    send_request(REQ_FLUSH, 48'hFFFF_FFFF_FFFF, LEN_W'(4096));
    // clean slot with another page: replaced without eviction
    send_request(REQ_WRITE, '0, LEN_W'(1));
    send_request(REQ_WRITE, 48'hAAAA_AAAA_AAAA, LEN_W'(4095));
    send_request(REQ_WRITE, 48'h5555_5555_5555, LEN_W'(13'h0555));
    send_request(REQ_WRITE, 48'h5555_5555_5555, LEN_W'(13'h0AAA));
    drain();
    write_reg(REG_WRITE_LIMIT, 1);
    send_request(REQ_WRITE, 48'h0000_0000_1234, LEN_W'(2));
    send_request(REQ_WRITE, 48'h0000_0000_1234, LEN_W'(1));
    drain();
    write_reg(REG_WRITE_LIMIT, 0);
    send_request(REQ_WRITE, 48'h0000_0000_2000, LEN_W'(1));
    send_request(REQ_FLUSH, '0, '0);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: lim = 4096;
        1: lim = $urandom_range(1, 4096);
        2: lim = $urandom_range(1, 64);
        3: lim = 4096;
        4: lim = 1;
        default: lim = $urandom_range(512, 4095);
      endcase
      write_reg(REG_STAGING_EN, (p == 3) ? 0 : 1);
      write_reg(REG_WRITE_LIMIT, lim);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 11) == 0) begin
          send_request(REQ_FLUSH, random_offset(), random_length(cur_limit));
        end else begin
          send_request(REQ_WRITE, random_offset(), random_length(cur_limit));
        end
      end
      drain();
    end

    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/dmwt_pkg.sv
rtl/dmwt_ram.sv
rtl/dmwt_ctrl.sv
rtl/dmwt_dp.sv
rtl/direct_mapped_writeback_tags.sv
rtl/dmwt_checker.sv
tb/writeback_tags_checker.sv
tb/direct_mapped_writeback_tags_test.sv
